[rtl/ptst_pkg.sv]
// ----------------------------------------------------------------------------
// ptst_pkg: shared types and constants of the polyline trail strip tessellator
// Item structs, controller states, datapath select codes and command/status.
// ----------------------------------------------------------------------------
package ptst_pkg;

    localparam int COORD_W   = 24;             // Q16.8 coordinates
    localparam int THICK_W   = 16;             // Q8.8 thickness
    localparam int COLOR_W   = 32;
    localparam int U_W       = 32;             // Q16.16 texture u
    localparam int TEXW_W    = 24;
    localparam int DELTA_W   = COORD_W + 1;
    localparam int PROD_W    = 2 * DELTA_W;
    localparam int D2_W      = PROD_W + 1;
    localparam int RAD_W     = 64;             // d2 << 14
    localparam int ROOT_W    = RAD_W / 2;
    localparam int SQ_REM_W  = ROOT_W + 3;
    localparam int DIV_W     = 48;
    localparam int OFF_W     = THICK_W + 1;    // offset magnitude, at most half thickness
    localparam int SUM_W     = COORD_W + 2;
    localparam int CNT_W     = 6;
    localparam logic [CNT_W-1:0] SQRT_STEPS = CNT_W'(ROOT_W - 1);
    localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(DIV_W - 1);
    localparam logic [TEXW_W-1:0] TEXW_RESET = TEXW_W'(256);

    typedef struct packed {
        logic                       first_point;
        logic signed [COORD_W-1:0]  point_x;
        logic signed [COORD_W-1:0]  point_y;
        logic [THICK_W-1:0]         point_thickness;
        logic [COLOR_W-1:0]         point_color;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]  vert_x;
        logic signed [COORD_W-1:0]  vert_y;
        logic [COLOR_W-1:0]         vert_color;
        logic [U_W-1:0]             tex_u;
        logic                       tex_v;
        logic                       last_vertex;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DELTA, S_CHECK, S_SQX, S_SQY, S_SQADD, S_SQRT_INIT, S_SQRT,
        S_DMUL, S_DINIT, S_DRUN, S_DSTORE, S_USUM, S_EMIT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        MUL_AXAX, MUL_AYAY, MUL_AYPT, MUL_AXPT, MUL_AYCT, MUL_AXCT
    } mul_sel_t;

    typedef enum logic [2:0] {
        DIV_OPX, DIV_OPY, DIV_OCX, DIV_OCY, DIV_DU
    } div_sel_t;

    typedef enum logic [2:0] {
        V_P_PLUS, V_P_MINUS0, V_C_PLUS0, V_P_MINUS1, V_C_PLUS1, V_C_MINUS
    } vert_t;

    typedef struct packed {
        logic       load_in;
        logic       calc_delta;
        logic       mul_en;
        mul_sel_t   mul_sel;
        logic       d2_load;
        logic       d2_add;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       div_store;
        div_sel_t   div_sel;
        logic       u_calc;
        logic       out_load;
        vert_t      vert;
        logic       store_first;
        logic       commit;
    } ptst_cmd_t;

    typedef struct packed {
        logic is_first;
        logic is_zero;
    } ptst_status_t;

endpackage

[rtl/polyline_trail_strip_tessellator.sv]
// ----------------------------------------------------------------------------
// polyline_trail_strip_tessellator: polyline points to two-triangle segments
// Controller plus datapath; one shared multiplier, root and divider unit.
// ----------------------------------------------------------------------------
// Usage:
//  - s_ channel takes one point item (first flag, Q16.8 x/y, Q8.8 thickness,
//    color). m_ channel gives vertex items, six per drawn segment, the sixth
//    flagged by last_vertex.
//  - cfg_wr_en/cfg_wr_data write the texture repeat width (Q16.8); write
//    only when idle.
//  - One item at a time. A first point or a repeated point passes IDLE,
//    DELTA and CHECK and gives no vertices. A segment point goes on through
//    the squares, the 32-step root (one bit per cycle) and five 48-step
//    divides through one shared restoring divider, then emits six vertices.
//    The serial divider sets the rate.
//  - Vertices leave through an output register; a stalled m_ready holds
//    the current vertex and pauses emission, nothing is dropped.
//  - Reset (aresetn low, synchronous) forgets the previous point, clears
//    running u and sets the texture width to 256.
// ----------------------------------------------------------------------------
module polyline_trail_strip_tessellator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [ptst_pkg::TEXW_W-1:0]   cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  ptst_pkg::in_item_t            s_item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output ptst_pkg::out_item_t           m_item
);

    ptst_pkg::ptst_cmd_t     cmd;
    ptst_pkg::ptst_status_t  status;

    // sequencer
    ptst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // arithmetic, point state and output register
    ptst_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_item      (s_item),
        .cmd         (cmd),
        .status      (status),
        .m_item      (m_item)
    );

endmodule

[rtl/ptst_datapath.sv]
// ----------------------------------------------------------------------------
// ptst_datapath: point storage, shared multiplier, square root and divider
// Executes controller commands; holds the output register.
// ----------------------------------------------------------------------------
module ptst_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [ptst_pkg::TEXW_W-1:0]      cfg_wr_data,
    input  ptst_pkg::in_item_t               s_item,
    input  ptst_pkg::ptst_cmd_t              cmd,
    output ptst_pkg::ptst_status_t           status,
    output ptst_pkg::out_item_t              m_item
);

    function automatic logic signed [ptst_pkg::COORD_W-1:0] sat_coord(
        input logic signed [ptst_pkg::SUM_W-1:0] v);
        logic signed [ptst_pkg::SUM_W-1:0] hi;
        logic signed [ptst_pkg::SUM_W-1:0] lo;
        hi = ptst_pkg::SUM_W'((2 ** (ptst_pkg::COORD_W - 1)) - 1);
        lo = -hi - ptst_pkg::SUM_W'(1);
        if (v > hi) begin
            return hi[ptst_pkg::COORD_W-1:0];
        end else if (v < lo) begin
            return lo[ptst_pkg::COORD_W-1:0];
        end
        return v[ptst_pkg::COORD_W-1:0];
    endfunction

    ptst_pkg::in_item_t                      cur_reg;
    logic signed [ptst_pkg::COORD_W-1:0]     prev_x_reg, prev_y_reg;
    logic [ptst_pkg::THICK_W-1:0]            prev_t_reg;
    logic [ptst_pkg::COLOR_W-1:0]            prev_c_reg;
    logic                                    have_prev_reg;
    logic [ptst_pkg::U_W-1:0]                run_u_reg, u1_reg;
    logic [ptst_pkg::TEXW_W-1:0]             texw_reg;
    logic signed [ptst_pkg::DELTA_W-1:0]     dx_reg, dy_reg;
    logic [ptst_pkg::PROD_W-1:0]             prod_reg;
    logic [ptst_pkg::D2_W-1:0]               d2_reg;
    logic [ptst_pkg::RAD_W-1:0]              rad_reg;
    logic [ptst_pkg::ROOT_W-1:0]             root_reg;
    logic [ptst_pkg::SQ_REM_W-1:0]           srem_reg;
    logic [ptst_pkg::DIV_W-1:0]              quo_reg, dden_reg, du_reg;
    logic [ptst_pkg::DIV_W:0]                drem_reg;
    logic [ptst_pkg::OFF_W-1:0]              opx_reg, opy_reg, ocx_reg, ocy_reg;
    ptst_pkg::out_item_t                     m_item_reg;

    logic [ptst_pkg::DELTA_W-1:0]            ax, ay, pt_ext, ct_ext, mul_a, mul_b;
    logic [ptst_pkg::SQ_REM_W-1:0]           srem_sh, trial;
    logic                                    sq_ge;
    logic [ptst_pkg::DIV_W:0]                dshift;
    logic                                    div_ge;
    logic [ptst_pkg::TEXW_W-1:0]             texw_eff;
    logic [ptst_pkg::DIV_W-1:0]              dnum, dden;
    logic [ptst_pkg::U_W:0]                  usum;
    logic                                    dx_pos;
    logic                                    use_cur, neg_off;
    logic signed [ptst_pkg::COORD_W-1:0]     bx, by;
    logic [ptst_pkg::OFF_W-1:0]              mx, my;
    logic                                    nx, ny;
    logic signed [ptst_pkg::SUM_W-1:0]       offx, offy, vx, vy;
    ptst_pkg::out_item_t                     vert;

    assign ax = dx_reg[ptst_pkg::DELTA_W-1] ? ptst_pkg::DELTA_W'(-dx_reg)
                                            : ptst_pkg::DELTA_W'(dx_reg);
    assign ay = dy_reg[ptst_pkg::DELTA_W-1] ? ptst_pkg::DELTA_W'(-dy_reg)
                                            : ptst_pkg::DELTA_W'(dy_reg);
    assign pt_ext = ptst_pkg::DELTA_W'(prev_t_reg);
    assign ct_ext = ptst_pkg::DELTA_W'(cur_reg.point_thickness);

    always_comb begin
        unique case (cmd.mul_sel)
            ptst_pkg::MUL_AXAX: begin mul_a = ax; mul_b = ax;     end
            ptst_pkg::MUL_AYAY: begin mul_a = ay; mul_b = ay;     end
            ptst_pkg::MUL_AYPT: begin mul_a = ay; mul_b = pt_ext; end
            ptst_pkg::MUL_AXPT: begin mul_a = ax; mul_b = pt_ext; end
            ptst_pkg::MUL_AYCT: begin mul_a = ay; mul_b = ct_ext; end
            ptst_pkg::MUL_AXCT: begin mul_a = ax; mul_b = ct_ext; end
            default:            begin mul_a = ax; mul_b = ax;     end
        endcase
    end

    // restoring square root, one result bit per step
    assign srem_sh = {srem_reg[ptst_pkg::SQ_REM_W-3:0], rad_reg[ptst_pkg::RAD_W-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign sq_ge   = srem_sh >= trial;

    // divider operands: rounded offsets, or rounded du
    assign texw_eff = (texw_reg == '0) ? ptst_pkg::TEXW_W'(1) : texw_reg;
    always_comb begin
        if (cmd.div_sel == ptst_pkg::DIV_DU) begin
            dnum = {7'd0, root_reg, 9'd0} + ptst_pkg::DIV_W'(texw_eff >> 1);
            dden = ptst_pkg::DIV_W'(texw_eff);
        end else begin
            dnum = {prod_reg[40:0], 7'd0} + ptst_pkg::DIV_W'(root_reg);
            dden = {15'd0, root_reg, 1'b0};
        end
    end

    assign dshift = {drem_reg[ptst_pkg::DIV_W-1:0], quo_reg[ptst_pkg::DIV_W-1]};
    assign div_ge = dshift >= {1'b0, dden_reg};
    assign usum   = {1'b0, run_u_reg} + {1'b0, du_reg[ptst_pkg::U_W-1:0]};
    assign dx_pos = !dx_reg[ptst_pkg::DELTA_W-1] && (dx_reg != '0);

    // vertex assembly
    always_comb begin
        use_cur = 1'b0;
        neg_off = 1'b0;
        unique case (cmd.vert)
            ptst_pkg::V_P_PLUS:   begin use_cur = 1'b0; neg_off = 1'b0; end
            ptst_pkg::V_P_MINUS0: begin use_cur = 1'b0; neg_off = 1'b1; end
            ptst_pkg::V_C_PLUS0:  begin use_cur = 1'b1; neg_off = 1'b0; end
            ptst_pkg::V_P_MINUS1: begin use_cur = 1'b0; neg_off = 1'b1; end
            ptst_pkg::V_C_PLUS1:  begin use_cur = 1'b1; neg_off = 1'b0; end
            ptst_pkg::V_C_MINUS:  begin use_cur = 1'b1; neg_off = 1'b1; end
            default:              begin use_cur = 1'b0; neg_off = 1'b0; end
        endcase
        bx = use_cur ? cur_reg.point_x : prev_x_reg;
        by = use_cur ? cur_reg.point_y : prev_y_reg;
        mx = use_cur ? ocx_reg : opx_reg;
        my = use_cur ? ocy_reg : opy_reg;
        // x offset follows dy's sign, y offset follows -dx's sign
        nx = dy_reg[ptst_pkg::DELTA_W-1] ^ neg_off;
        ny = dx_pos ^ neg_off;
        offx = nx ? -$signed(ptst_pkg::SUM_W'(mx)) : $signed(ptst_pkg::SUM_W'(mx));
        offy = ny ? -$signed(ptst_pkg::SUM_W'(my)) : $signed(ptst_pkg::SUM_W'(my));
        vx = ptst_pkg::SUM_W'(bx) + offx;
        vy = ptst_pkg::SUM_W'(by) + offy;
        vert.vert_x      = sat_coord(vx);
        vert.vert_y      = sat_coord(vy);
        vert.vert_color  = use_cur ? cur_reg.point_color : prev_c_reg;
        vert.tex_u       = use_cur ? u1_reg : run_u_reg;
        vert.tex_v       = !neg_off;
        vert.last_vertex = (cmd.vert == ptst_pkg::V_C_MINUS);
    end

    // control-type state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
            run_u_reg     <= '0;
            texw_reg      <= ptst_pkg::TEXW_RESET;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_t_reg    <= '0;
            prev_c_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                texw_reg <= cfg_wr_data;
            end
            if (cmd.store_first || cmd.commit) begin
                have_prev_reg <= 1'b1;
                prev_x_reg    <= cur_reg.point_x;
                prev_y_reg    <= cur_reg.point_y;
                prev_t_reg    <= cur_reg.point_thickness;
                prev_c_reg    <= cur_reg.point_color;
                run_u_reg     <= cmd.commit ? u1_reg : '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cur_reg <= s_item;
        end
        if (cmd.calc_delta) begin
            dx_reg <= ptst_pkg::DELTA_W'(cur_reg.point_x) - ptst_pkg::DELTA_W'(prev_x_reg);
            dy_reg <= ptst_pkg::DELTA_W'(cur_reg.point_y) - ptst_pkg::DELTA_W'(prev_y_reg);
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.d2_load) begin
            d2_reg <= ptst_pkg::D2_W'(prod_reg);
        end else if (cmd.d2_add) begin
            d2_reg <= d2_reg + ptst_pkg::D2_W'(prod_reg);
        end
        if (cmd.sqrt_init) begin
            rad_reg  <= {d2_reg[ptst_pkg::RAD_W-15:0], 14'd0};
            root_reg <= '0;
            srem_reg <= '0;
        end else if (cmd.sqrt_step) begin
            rad_reg  <= {rad_reg[ptst_pkg::RAD_W-3:0], 2'b00};
            root_reg <= {root_reg[ptst_pkg::ROOT_W-2:0], sq_ge};
            srem_reg <= sq_ge ? (srem_sh - trial) : srem_sh;
        end
        if (cmd.div_init) begin
            quo_reg  <= dnum;
            dden_reg <= dden;
            drem_reg <= '0;
        end else if (cmd.div_step) begin
            quo_reg  <= {quo_reg[ptst_pkg::DIV_W-2:0], div_ge};
            drem_reg <= div_ge ? (dshift - {1'b0, dden_reg}) : dshift;
        end
        if (cmd.div_store) begin
            unique case (cmd.div_sel)
                ptst_pkg::DIV_OPX: opx_reg <= quo_reg[ptst_pkg::OFF_W-1:0];
                ptst_pkg::DIV_OPY: opy_reg <= quo_reg[ptst_pkg::OFF_W-1:0];
                ptst_pkg::DIV_OCX: ocx_reg <= quo_reg[ptst_pkg::OFF_W-1:0];
                ptst_pkg::DIV_OCY: ocy_reg <= quo_reg[ptst_pkg::OFF_W-1:0];
                ptst_pkg::DIV_DU:  du_reg  <= quo_reg;
                default:           du_reg  <= quo_reg;
            endcase
        end
        if (cmd.u_calc) begin
            u1_reg <= ((|du_reg[ptst_pkg::DIV_W-1:ptst_pkg::U_W]) || usum[ptst_pkg::U_W])
                      ? '1 : usum[ptst_pkg::U_W-1:0];
        end
        if (cmd.out_load) begin
            m_item_reg <= vert;
        end
    end

    assign status.is_first = cur_reg.first_point || !have_prev_reg;
    assign status.is_zero  = (dx_reg == '0) && (dy_reg == '0);
    assign m_item          = m_item_reg;

endmodule

[rtl/ptst_ctrl.sv]
// ----------------------------------------------------------------------------
// ptst_ctrl: sequencing state machine
// Steps the datapath through delta, squares, root, five divides and emission.
// ----------------------------------------------------------------------------
module ptst_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    input  ptst_pkg::ptst_status_t  status,
    output ptst_pkg::ptst_cmd_t     cmd
);

    ptst_pkg::ctrl_state_t          state_reg, state_next;
    logic [ptst_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    ptst_pkg::div_sel_t             k_reg, k_next;
    ptst_pkg::vert_t                vidx_reg, vidx_next;
    logic                           m_valid_reg, m_valid_next;
    logic                           out_free;

    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ptst_pkg::S_IDLE:      if (s_valid) state_next = ptst_pkg::S_DELTA;
            ptst_pkg::S_DELTA:     state_next = ptst_pkg::S_CHECK;
            ptst_pkg::S_CHECK: begin
                if (status.is_first || status.is_zero) state_next = ptst_pkg::S_IDLE;
                else                                   state_next = ptst_pkg::S_SQX;
            end
            ptst_pkg::S_SQX:       state_next = ptst_pkg::S_SQY;
            ptst_pkg::S_SQY:       state_next = ptst_pkg::S_SQADD;
            ptst_pkg::S_SQADD:     state_next = ptst_pkg::S_SQRT_INIT;
            ptst_pkg::S_SQRT_INIT: state_next = ptst_pkg::S_SQRT;
            ptst_pkg::S_SQRT:      if (cnt_reg == '0) state_next = ptst_pkg::S_DMUL;
            ptst_pkg::S_DMUL:      state_next = ptst_pkg::S_DINIT;
            ptst_pkg::S_DINIT:     state_next = ptst_pkg::S_DRUN;
            ptst_pkg::S_DRUN:      if (cnt_reg == '0) state_next = ptst_pkg::S_DSTORE;
            ptst_pkg::S_DSTORE: begin
                if (k_reg == ptst_pkg::DIV_DU) state_next = ptst_pkg::S_USUM;
                else                           state_next = ptst_pkg::S_DMUL;
            end
            ptst_pkg::S_USUM:      state_next = ptst_pkg::S_EMIT;
            ptst_pkg::S_EMIT: begin
                if (out_free && vidx_reg == ptst_pkg::V_C_MINUS) state_next = ptst_pkg::S_IDLE;
            end
            default:               state_next = ptst_pkg::S_IDLE;
        endcase
    end

    // outputs and counters
    always_comb begin
        cmd          = '0;
        cmd.mul_sel  = ptst_pkg::MUL_AXAX;
        cmd.div_sel  = k_reg;
        cmd.vert     = vidx_reg;
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        vidx_next    = vidx_reg;
        s_ready      = 1'b0;
        unique case (k_reg)
            ptst_pkg::DIV_OPX: cmd.mul_sel = ptst_pkg::MUL_AYPT;
            ptst_pkg::DIV_OPY: cmd.mul_sel = ptst_pkg::MUL_AXPT;
            ptst_pkg::DIV_OCX: cmd.mul_sel = ptst_pkg::MUL_AYCT;
            ptst_pkg::DIV_OCY: cmd.mul_sel = ptst_pkg::MUL_AXCT;
            default:           cmd.mul_sel = ptst_pkg::MUL_AXAX;
        endcase
        unique case (state_reg)
            ptst_pkg::S_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            ptst_pkg::S_DELTA: cmd.calc_delta = 1'b1;
            ptst_pkg::S_CHECK: cmd.store_first = status.is_first;
            ptst_pkg::S_SQX: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = ptst_pkg::MUL_AXAX;
            end
            ptst_pkg::S_SQY: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = ptst_pkg::MUL_AYAY;
                cmd.d2_load = 1'b1;
            end
            ptst_pkg::S_SQADD: cmd.d2_add = 1'b1;
            ptst_pkg::S_SQRT_INIT: begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = ptst_pkg::SQRT_STEPS;
            end
            ptst_pkg::S_SQRT: begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg - 1'b1;
                k_next        = ptst_pkg::DIV_OPX;
            end
            ptst_pkg::S_DMUL: cmd.mul_en = 1'b1;
            ptst_pkg::S_DINIT: begin
                cmd.div_init = 1'b1;
                cnt_next     = ptst_pkg::DIV_STEPS;
            end
            ptst_pkg::S_DRUN: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
            end
            ptst_pkg::S_DSTORE: begin
                cmd.div_store = 1'b1;
                if (k_reg != ptst_pkg::DIV_DU) begin
                    k_next = ptst_pkg::div_sel_t'(3'(k_reg + 3'd1));
                end
            end
            ptst_pkg::S_USUM: begin
                cmd.u_calc = 1'b1;
                vidx_next  = ptst_pkg::V_P_PLUS;
            end
            ptst_pkg::S_EMIT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    if (vidx_reg == ptst_pkg::V_C_MINUS) begin
                        cmd.commit = 1'b1;
                    end else begin
                        vidx_next = ptst_pkg::vert_t'(3'(vidx_reg + 3'd1));
                    end
                end
            end
            default: ;
        endcase
        m_valid_next = cmd.out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ptst_pkg::S_IDLE;
            cnt_reg     <= '0;
            k_reg       <= ptst_pkg::DIV_OPX;
            vidx_reg    <= ptst_pkg::V_P_PLUS;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            k_reg       <= k_next;
            vidx_reg    <= vidx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

[rtl/ptst_checker.sv]
// ----------------------------------------------------------------------------
// ptst_checker: port-level checks for the tessellator
// Bound to the top level.
// ----------------------------------------------------------------------------
module ptst_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input ptst_pkg::in_item_t   s_item,
    input logic                 m_valid,
    input logic                 m_ready,
    input ptst_pkg::out_item_t  m_item
);

    // held vertex stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("vertex changed while stalled");

    // waiting point stays put
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_item))
        else $error("point changed while waiting");

    // one point in flight
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second point taken during work");

    // sixth vertex is on the minus side
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.last_vertex |-> !m_item.tex_v)
        else $error("last vertex on plus side");

    // reset empties the output
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind polyline_trail_strip_tessellator ptst_checker u_ptst_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

[sim/tb_polyline_trail_strip_tessellator.sv]
// ----------------------------------------------------------------------------
// tb_polyline_trail_strip_tessellator: self-checking bench for the tessellator
// Feeds point items with random gaps, predicts each segment's six vertices
// with a fixed-point model of its own and compares every vertex item.
// ----------------------------------------------------------------------------
module tb_polyline_trail_strip_tessellator;

    localparam int WATCHDOG_LIMIT = 4000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [ptst_pkg::TEXW_W-1:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    ptst_pkg::in_item_t  s_item = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    ptst_pkg::out_item_t m_item;

    polyline_trail_strip_tessellator dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Trail state of the predictor
    logic [ptst_pkg::TEXW_W-1:0] tex_width_q;
    logic              trail_open;
    logic signed [63:0] prev_x, prev_y;
    logic [15:0]       prev_thick;
    logic [31:0]       last_color;
    logic [31:0]       trail_u;

    ptst_pkg::in_item_t  point_queue[$];
    ptst_pkg::out_item_t vertex_queue[$];
    int        mismatches = 0;
    int        points_sent = 0;
    int        vertices_seen = 0;
    int        idle_cycles = 0;
    bit        stim_done = 0;
    bit        hold_sender = 0;

    // Short gaps mostly, now and then a long one, sometimes none at all
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [127:0] rad);
        logic [63:0] root;
        logic [127:0] rem, trial;
        root = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = (rem << 2) | ((rad >> (2 * i)) & 128'd3);
            trial = {root, 2'b01};
            root = root << 1;
            if (rem >= trial) begin
                rem = rem - trial;
                root[0] = 1'b1;
            end
        end
        return root;
    endfunction

    // Round half away from zero
    function automatic logic signed [63:0] div_round(logic signed [63:0] num,
                                                     logic [63:0] den);
        logic [63:0] mag, q;
        mag = (num < 0) ? -num : num;
        q = (mag * 2 + den) / (den * 2);
        return (num < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [ptst_pkg::COORD_W-1:0] clamp_coord(
        logic signed [63:0] v);
        if (v > 64'sd8388607) return 24'sh7FFFFF;
        if (v < -64'sd8388608) return 24'sh800000;
        return v[ptst_pkg::COORD_W-1:0];
    endfunction

    function automatic ptst_pkg::out_item_t make_vertex(logic signed [63:0] x,
                                                        logic signed [63:0] y,
                                                        logic [31:0] col, logic [31:0] u,
                                                        logic v, logic last);
        ptst_pkg::out_item_t o;
        o.vert_x = clamp_coord(x);
        o.vert_y = clamp_coord(y);
        o.vert_color = col;
        o.tex_u = u;
        o.tex_v = v;
        o.last_vertex = last;
        return o;
    endfunction

    // Predicts the vertices caused by one accepted point
    task automatic tessellate_point(ptst_pkg::in_item_t p);
        logic signed [63:0] cx, cy, dx, dy, opx, opy, ocx, ocy;
        logic [127:0] d2;
        logic [63:0] len, w, du, ue;
        logic [31:0] u0, u1;
        cx = p.point_x;
        cy = p.point_y;
        if (p.first_point || !trail_open) begin
            trail_open = 1;
            prev_x = cx; prev_y = cy;
            prev_thick = p.point_thickness; last_color = p.point_color;
            trail_u = '0;
            return;
        end
        dx = cx - prev_x;
        dy = cy - prev_y;
        if (dx == 0 && dy == 0) return;      // repeated point: dropped
        d2 = 128'(dx * dx) + 128'(dy * dy);
        len = int_sqrt(d2 << 14);
        opx = div_round(dy * $signed({48'd0, prev_thick}) * 64, len);
        opy = div_round(-dx * $signed({48'd0, prev_thick}) * 64, len);
        ocx = div_round(dy * $signed({48'd0, p.point_thickness}) * 64, len);
        ocy = div_round(-dx * $signed({48'd0, p.point_thickness}) * 64, len);
        w = (tex_width_q == 0) ? 64'd1 : 64'(tex_width_q);
        du = (len * 512 + w / 2) / w;
        u0 = trail_u;
        ue = 64'(u0) + du;
        if (ue > 64'hFFFF_FFFF) ue = 64'hFFFF_FFFF;
        u1 = ue[31:0];
        vertex_queue.push_back(make_vertex(prev_x + opx, prev_y + opy, last_color, u0, 1, 0));
        vertex_queue.push_back(make_vertex(prev_x - opx, prev_y - opy, last_color, u0, 0, 0));
        vertex_queue.push_back(make_vertex(cx + ocx, cy + ocy, p.point_color, u1, 1, 0));
        vertex_queue.push_back(make_vertex(prev_x - opx, prev_y - opy, last_color, u0, 0, 0));
        vertex_queue.push_back(make_vertex(cx + ocx, cy + ocy, p.point_color, u1, 1, 0));
        vertex_queue.push_back(make_vertex(cx - ocx, cy - ocy, p.point_color, u1, 0, 1));
        prev_x = cx; prev_y = cy;
        prev_thick = p.point_thickness; last_color = p.point_color;
        trail_u = u1;
    endtask

    function automatic ptst_pkg::in_item_t mk_point(logic first, int x, int y, int t,
                                                    logic [31:0] c);
        ptst_pkg::in_item_t p;
        p.first_point = first;
        p.point_x = x[23:0];
        p.point_y = y[23:0];
        p.point_thickness = t[15:0];
        p.point_color = c;
        return p;
    endfunction

    // Driver: one item at a time from point_queue, random gaps between
    int send_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                tessellate_point(s_item);
                points_sent++;
                send_gap = gap_len();
            end
            if (!(s_valid && !s_ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (!hold_sender && point_queue.size() > 0) begin
                    s_valid <= 1'b1;
                    s_item <= point_queue.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each vertex with the oldest prediction
    int stall = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                vertices_seen++;
                if (vertex_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected vertex %p", m_item);
                end else begin
                    ptst_pkg::out_item_t e;
                    e = vertex_queue.pop_front();
                    if (e !== m_item) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("vertex mismatch: expected %p, got %p", e, m_item);
                    end
                end
            end
            // random back-pressure
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else begin
                stall = gap_len();
                m_ready <= 1'b1;
            end
            // watchdog on cycles with no accepted item
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT && !(stim_done && vertex_queue.size() == 0)) begin
                $display("watchdog expired with %0d vertices pending", vertex_queue.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    // Waits until all queued points are taken and all vertices are back
    task automatic drain();
        while (point_queue.size() > 0 || s_valid) @(posedge aclk);
        while (vertex_queue.size() > 0) @(posedge aclk);
        repeat (350) @(posedge aclk);    // a dropped point may still be in flight
    endtask

    task automatic write_tex_width(logic [ptst_pkg::TEXW_W-1:0] w);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= w;
        tex_width_q = w;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Random trail: mostly short moves, some long, some repeats
    task automatic queue_trail(int n);
        int x, y, r;
        x = $signed(24'($urandom));
        y = $signed(24'($urandom));
        point_queue.push_back(mk_point(1, x, y, $urandom_range(0, 65535), $urandom));
        for (int i = 1; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                x += $signed(12'($urandom)); y += $signed(12'($urandom));
            end else if (r < 85) begin
                x = $signed(24'($urandom)); y = $signed(24'($urandom));
            end else if (r >= 92) begin
                x += $urandom_range(0, 2) - 1; y += $urandom_range(0, 2) - 1;
            end
            x = $signed(x[23:0]); y = $signed(y[23:0]);
            point_queue.push_back(mk_point(r == 99, x, y,
                                           $urandom_range(0, 9) == 0 ? 65535 :
                                           $urandom_range(0, 65535), $urandom));
        end
    endtask

    initial begin
        int texw[4];
        tex_width_q = ptst_pkg::TEXW_RESET;
        trail_open = 0;
        prev_x = 0; prev_y = 0; prev_thick = 0; last_color = 0; trail_u = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: no previous point yet, extremes, repeated point,
        // saturation at the corners, new trail mid-stream
        point_queue.push_back(mk_point(0, 0, 0, 512, 32'h11223344));
        point_queue.push_back(mk_point(0, 256, 0, 512, 32'h55667788));
        point_queue.push_back(mk_point(0, 256, 0, 100, 32'h0));
        point_queue.push_back(mk_point(0, 256, 256, 0, 32'hFFFFFFFF));
        point_queue.push_back(mk_point(0, 8388607, 8388607, 65535, 32'hA5A5A5A5));
        point_queue.push_back(mk_point(0, -8388608, -8388608, 65535, 32'h5A5A5A5A));
        point_queue.push_back(mk_point(0, -8388608, 8388607, 65535, 32'hFFFF0000));
        point_queue.push_back(mk_point(0, 8388607, -8388608, 1, 32'h0000FFFF));
        point_queue.push_back(mk_point(0, 8388606, -8388608, 65535, 32'h1));
        point_queue.push_back(mk_point(1, 100, -100, 300, 32'hDEADBEEF));
        point_queue.push_back(mk_point(0, 101, -100, 300, 32'hCAFEF00D));
        point_queue.push_back(mk_point(0, 101, -99, 65535, 32'h12345678));
        point_queue.push_back(mk_point(1, -5, 7, 0, 32'h0));
        point_queue.push_back(mk_point(0, -5, 7, 0, 32'h0));
        point_queue.push_back(mk_point(0, -6000, 7000, 40000, 32'h80000001));
        drain();

        // Tiny texture width drives u to saturation; widest, zero and random
        texw[0] = 1; texw[1] = 24'hFFFFFF; texw[2] = 0; texw[3] = $urandom_range(1, 65535);
        for (int k = 0; k < 4; k++) begin
            write_tex_width(texw[k][23:0]);
            queue_trail(6);
            if (k == 0) begin
                // far jumps so u pins at the top
                for (int i = 0; i < 4; i++)
                    point_queue.push_back(mk_point(0, (i % 2) ? 8388607 : -8388608,
                                                   (i % 2) ? -8388608 : 8388607, 256, $urandom));
            end
            drain();
        end

        write_tex_width(ptst_pkg::TEXW_RESET);
        for (int t = 0; t < 20; t++) begin
            queue_trail($urandom_range(6, 14));
            if (t == 10) begin
                // sender holds off until every vertex is back
                hold_sender = 1;
                while (vertex_queue.size() > 0 || s_valid) @(posedge aclk);
                hold_sender = 0;
            end
            if (t % 5 == 4) begin
                drain();
                write_tex_width($urandom_range(1, 24'hFFFFFF));
            end
        end
        drain();
        stim_done = 1;

        $display("sent %0d points over several trails, checked %0d vertices", points_sent,
                 vertices_seen);
        $display("covered texture widths 0, 1, max and random, corner coordinates, repeats");
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL");
        end
        $finish;
    end
endmodule
